// ===== sv/sstl_pkg.sv =====
// shared types, constants and lookup functions of the six-step speed trim loop
package sstl_pkg;

    // field widths
    localparam int TICKS_W  = 32;
    localparam int TICKS8_W = TICKS_W - 3;
    localparam int BEMF_W   = 12;
    localparam int LEVEL_W  = 3;
    localparam int STEP_W   = 27;
    localparam int ERR_W    = 28;
    localparam int SUM_W    = 31;
    localparam int DUTY_W   = 5;
    localparam int THR_W    = 7;
    localparam int ADJ_W    = 5;
    localparam int REF_W    = 10;
    localparam int TOL_W    = 7;

    // divide by six as an exact reciprocal multiply on ticks / 8
    localparam int STEP_DIV_K  = 32;
    localparam int STEP_DIV_W  = 30;
    localparam int STEP_PROD_W = TICKS8_W + STEP_DIV_W;
    localparam logic [STEP_DIV_W-1:0] STEP_DIV_M = 30'd715827883;

    // trim limits
    localparam logic [DUTY_W-1:0] DUTY_MIN  = 5'd3;
    localparam logic [DUTY_W-1:0] DUTY_MAX  = 5'd20;
    localparam logic [THR_W-1:0]  THR_MIN   = 7'd5;
    localparam logic [THR_W-1:0]  THR_MAX   = 7'd100;
    localparam logic [ADJ_W-1:0]  ADJ_LIMIT = 5'd30;

    // speed level codes
    localparam logic [LEVEL_W-1:0] LEVEL_STOP = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_1000 = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_800  = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_500  = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_250  = 3'd4;

    // operating mode seen by the stages
    typedef struct packed {
        logic             stopped;
        logic             clear;
        logic [REF_W-1:0] ref_us;
        logic [TOL_W-1:0] tol_us;
    } t_mode;

    // item after the step time divide
    typedef struct packed {
        logic [STEP_W-1:0] step_us;
        logic              bemf_zero;
    } t_step;

    // item after accumulation
    typedef struct packed {
        logic [SUM_W-1:0]  sum_total;
        logic [STEP_W-1:0] step_us;
        logic              eval;
        logic              bemf_zero;
    } t_acc;

    // item after the average divide
    typedef struct packed {
        logic [STEP_W-1:0] avg_us;
        logic [STEP_W-1:0] step_us;
        logic              eval;
        logic              bemf_zero;
    } t_avg;

    // level is stopped or unknown
    function automatic logic level_stopped(input logic [LEVEL_W-1:0] level);
        logic res;
        unique case (level)
            LEVEL_1000, LEVEL_800, LEVEL_500, LEVEL_250: res = 1'b0;
            default: res = 1'b1;
        endcase
        return res;
    endfunction

    // reference step time per level
    function automatic logic [REF_W-1:0] level_ref_us(input logic [LEVEL_W-1:0] level);
        logic [REF_W-1:0] res;
        unique case (level)
            LEVEL_1000: res = 10'd1000;
            LEVEL_800:  res = 10'd800;
            LEVEL_500:  res = 10'd500;
            LEVEL_250:  res = 10'd250;
            default:    res = '0;
        endcase
        return res;
    endfunction

    // tolerance band per level
    function automatic logic [TOL_W-1:0] level_tol_us(input logic [LEVEL_W-1:0] level);
        logic [TOL_W-1:0] res;
        unique case (level)
            LEVEL_1000: res = 7'd100;
            LEVEL_800:  res = 7'd50;
            LEVEL_500:  res = 7'd50;
            LEVEL_250:  res = 7'd50;
            default:    res = '0;
        endcase
        return res;
    endfunction

endpackage

// ===== sv/sixstep_speed_trim_loop.sv =====
// Six-step speed trim loop top level. One item per electrical cycle goes through five
// register stages (input, divide by 48, window accumulate, average divide, trim and
// result), and a new item can be accepted every cycle; under backpressure each stage
// holds its item while the stages behind it fill up, so at most five items are in
// flight. Writing speed level 0 or an unknown level clears all trim state at the
// write; the configuration port is always ready, a new level applies to items
// processed from the next cycle on, and the level must be written only while no item
// is in flight; the block itself does not enforce this.
module sixstep_speed_trim_loop #(
    parameter int EVAL_CYCLES = 10,
    parameter int SYNC_CYCLES = 50
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sstl_pkg::LEVEL_W-1:0]        i_cfg_speed_level,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [sstl_pkg::TICKS_W-1:0]        i_cycle_ticks,
    input  logic [sstl_pkg::BEMF_W-1:0]         i_bemf_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [sstl_pkg::DUTY_W-1:0]         o_pwm_duty,
    output logic [sstl_pkg::THR_W-1:0]          o_bemf_threshold,
    output logic [sstl_pkg::STEP_W-1:0]         o_step_time_us,
    output logic [sstl_pkg::STEP_W-1:0]         o_avg_step_us,
    output logic signed [sstl_pkg::ERR_W-1:0]   o_step_error,
    output logic                                o_evaluated
);

    logic [sstl_pkg::LEVEL_W-1:0]  r_speed_level;
    sstl_pkg::t_mode               mode;
    logic                          step_valid;
    logic                          step_ready;
    sstl_pkg::t_step               step_data;
    logic                          acc_valid;
    logic                          acc_ready;
    sstl_pkg::t_acc                acc_data;
    logic                          avg_valid;
    logic                          avg_ready;
    sstl_pkg::t_avg                avg_data;

    // speed level register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_level <= sstl_pkg::LEVEL_STOP;
        end else if (i_cfg_valid) begin
            r_speed_level <= i_cfg_speed_level;
        end
    end

    // mode decode
    always_comb begin
        mode.stopped = sstl_pkg::level_stopped(r_speed_level);
        mode.clear   = i_cfg_valid && sstl_pkg::level_stopped(i_cfg_speed_level);
        mode.ref_us  = sstl_pkg::level_ref_us(r_speed_level);
        mode.tol_us  = sstl_pkg::level_tol_us(r_speed_level);
    end

    // pipeline
    sstl_step_div u_step_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_cycle_ticks (i_cycle_ticks),
        .i_bemf_value  (i_bemf_value),
        .o_valid       (step_valid),
        .i_ready       (step_ready),
        .o_data        (step_data)
    );

    sstl_accum #(
        .EVAL_CYCLES (EVAL_CYCLES)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (mode),
        .i_valid (step_valid),
        .o_ready (step_ready),
        .i_data  (step_data),
        .o_valid (acc_valid),
        .i_ready (acc_ready),
        .o_data  (acc_data)
    );

    sstl_avg_div #(
        .EVAL_CYCLES (EVAL_CYCLES)
    ) u_avg_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc_valid),
        .o_ready (acc_ready),
        .i_data  (acc_data),
        .o_valid (avg_valid),
        .i_ready (avg_ready),
        .o_data  (avg_data)
    );

    sstl_trim #(
        .SYNC_CYCLES (SYNC_CYCLES)
    ) u_trim (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mode           (mode),
        .i_valid          (avg_valid),
        .o_ready          (avg_ready),
        .i_data           (avg_data),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_pwm_duty       (o_pwm_duty),
        .o_bemf_threshold (o_bemf_threshold),
        .o_step_time_us   (o_step_time_us),
        .o_avg_step_us    (o_avg_step_us),
        .o_step_error     (o_step_error),
        .o_evaluated      (o_evaluated)
    );

endmodule

// ===== sv/sstl_step_div.sv =====
// input register and cycle ticks to mean step time divide
module sstl_step_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sstl_pkg::TICKS_W-1:0]  i_cycle_ticks,
    input  logic [sstl_pkg::BEMF_W-1:0]   i_bemf_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output sstl_pkg::t_step               o_data
);

    logic                              r_in_valid;
    logic [sstl_pkg::TICKS8_W-1:0]     r_ticks8;
    logic                              r_bemf_zero;
    logic                              r_out_valid;
    sstl_pkg::t_step                   r_step;
    logic                              out_ready;
    logic [sstl_pkg::STEP_PROD_W-1:0]  prod;
    sstl_pkg::t_step                   n_step;

    // stage readiness
    assign out_ready = !r_out_valid || i_ready;
    assign o_ready   = !r_in_valid || out_ready;

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // input register payload, ticks already divided by 8
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ticks8    <= i_cycle_ticks[sstl_pkg::TICKS_W-1:3];
            r_bemf_zero <= (i_bemf_value == '0);
        end
    end

    // divide by 6 through the reciprocal, exact over the whole tick range
    always_comb begin
        prod = sstl_pkg::STEP_PROD_W'(r_ticks8)
             * sstl_pkg::STEP_PROD_W'(sstl_pkg::STEP_DIV_M);
        n_step.step_us   = prod[sstl_pkg::STEP_DIV_K +: sstl_pkg::STEP_W];
        n_step.bemf_zero = r_bemf_zero;
    end

    // step time register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_in_valid) begin
            r_step <= n_step;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_step;

endmodule

// ===== sv/sstl_accum.sv =====
// cycle counter and step time accumulator for the evaluation window
module sstl_accum #(
    parameter int EVAL_CYCLES = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sstl_pkg::t_mode   i_mode,
    input  logic              i_valid,
    output logic              o_ready,
    input  sstl_pkg::t_step   i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output sstl_pkg::t_acc    o_data
);

    localparam int CNT_W = (EVAL_CYCLES > 1) ? $clog2(EVAL_CYCLES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(EVAL_CYCLES - 1);

    logic [CNT_W-1:0]              r_count;
    logic [sstl_pkg::SUM_W-1:0]    r_sum;
    logic                          r_valid;
    sstl_pkg::t_acc                r_data;
    logic [CNT_W-1:0]              n_count;
    logic [sstl_pkg::SUM_W-1:0]    n_sum;
    sstl_pkg::t_acc                n_data;
    logic                          take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    // window accumulation, cleared when the window closes or the level stops
    always_comb begin
        n_data.sum_total = r_sum + sstl_pkg::SUM_W'(i_data.step_us);
        n_data.step_us   = i_data.step_us;
        n_data.eval      = (r_count == CNT_LAST);
        n_data.bemf_zero = i_data.bemf_zero;
        n_count          = r_count + CNT_W'(1);
        n_sum            = n_data.sum_total;
        if (i_mode.stopped) begin
            n_data.sum_total = '0;
            n_data.step_us   = '0;
            n_data.eval      = 1'b0;
            n_count          = '0;
            n_sum            = '0;
        end else if (n_data.eval) begin
            n_count = '0;
            n_sum   = '0;
        end
    end

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_mode.clear) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (take) begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== sv/sstl_avg_div.sv =====
// window sum to average step time, exact reciprocal multiply by 1 / EVAL_CYCLES
module sstl_avg_div #(
    parameter int EVAL_CYCLES = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sstl_pkg::t_acc    i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output sstl_pkg::t_avg    o_data
);

    localparam int DIV_L   = $clog2(EVAL_CYCLES);
    localparam int DIV_K   = sstl_pkg::SUM_W + DIV_L;
    localparam int DIV_M_W = 33;
    localparam int PROD_W  = sstl_pkg::SUM_W + DIV_M_W;
    localparam logic [DIV_M_W-1:0] DIV_M =
        DIV_M_W'(((64'd1 << DIV_K) + 64'(EVAL_CYCLES) - 64'd1) / 64'(EVAL_CYCLES));

    logic                 r_valid;
    sstl_pkg::t_avg       r_data;
    logic [PROD_W-1:0]    prod;
    sstl_pkg::t_avg       n_data;

    assign o_ready = !r_valid || i_ready;

    // quotient is exact for any sum below 2^31
    always_comb begin
        prod             = PROD_W'(i_data.sum_total) * PROD_W'(DIV_M);
        n_data.avg_us    = prod[DIV_K +: sstl_pkg::STEP_W];
        n_data.step_us   = i_data.step_us;
        n_data.eval      = i_data.eval;
        n_data.bemf_zero = i_data.bemf_zero;
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== sv/sstl_trim.sv =====
// evaluation, threshold and duty trim state, result register
module sstl_trim #(
    parameter int SYNC_CYCLES = 50
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sstl_pkg::t_mode                     i_mode,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  sstl_pkg::t_avg                      i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sstl_pkg::DUTY_W-1:0]         o_pwm_duty,
    output logic [sstl_pkg::THR_W-1:0]          o_bemf_threshold,
    output logic [sstl_pkg::STEP_W-1:0]         o_step_time_us,
    output logic [sstl_pkg::STEP_W-1:0]         o_avg_step_us,
    output logic signed [sstl_pkg::ERR_W-1:0]   o_step_error,
    output logic                                o_evaluated
);

    localparam int SYNC_W = $clog2(SYNC_CYCLES + 2);
    localparam logic [SYNC_W-1:0] SYNC_LAST = SYNC_W'(SYNC_CYCLES);

    logic                                r_valid;
    logic [SYNC_W-1:0]                   r_sync;
    logic [sstl_pkg::ADJ_W-1:0]          r_adj;
    logic [sstl_pkg::THR_W-1:0]          r_thr;
    logic [sstl_pkg::DUTY_W-1:0]         r_duty;
    logic [sstl_pkg::STEP_W-1:0]         r_last_avg;
    logic signed [sstl_pkg::ERR_W-1:0]   r_last_err;
    logic [sstl_pkg::STEP_W-1:0]         r_step_us;
    logic                                r_eval;
    logic [SYNC_W-1:0]                   n_sync;
    logic [sstl_pkg::ADJ_W-1:0]          n_adj;
    logic [sstl_pkg::THR_W-1:0]          n_thr;
    logic [sstl_pkg::DUTY_W-1:0]         n_duty;
    logic [sstl_pkg::STEP_W-1:0]         n_last_avg;
    logic signed [sstl_pkg::ERR_W-1:0]   n_last_err;
    logic signed [sstl_pkg::ERR_W-1:0]   err;
    logic [sstl_pkg::STEP_W-1:0]         band_hi;
    logic [sstl_pkg::STEP_W-1:0]         band_lo;
    logic                                slow;
    logic                                fast;
    logic                                take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    // error against the reference and tolerance band
    always_comb begin
        err = signed'(sstl_pkg::ERR_W'(i_data.avg_us))
            - signed'(sstl_pkg::ERR_W'(i_mode.ref_us));
        band_hi = sstl_pkg::STEP_W'(i_mode.ref_us) + sstl_pkg::STEP_W'(i_mode.tol_us);
        band_lo = sstl_pkg::STEP_W'(i_mode.ref_us) - sstl_pkg::STEP_W'(i_mode.tol_us);
        slow    = (i_data.avg_us > band_hi);
        fast    = (i_data.avg_us < band_lo);
    end

    // trim update for one item
    always_comb begin
        n_sync     = r_sync;
        n_adj      = r_adj;
        n_thr      = r_thr;
        n_duty     = r_duty;
        n_last_avg = r_last_avg;
        n_last_err = r_last_err;
        if (i_mode.stopped) begin
            n_sync     = '0;
            n_adj      = '0;
            n_thr      = '0;
            n_duty     = sstl_pkg::DUTY_MIN;
            n_last_avg = '0;
            n_last_err = '0;
        end else begin
            if (i_data.eval) begin
                n_last_avg = i_data.avg_us;
                n_last_err = err;
                if (r_sync <= SYNC_LAST) begin
                    // still syncing
                    n_sync = r_sync + SYNC_W'(1);
                    n_adj  = '0;
                end else if (r_adj <= sstl_pkg::ADJ_LIMIT) begin
                    // threshold nudge phase
                    if (slow) begin
                        if (r_thr < sstl_pkg::THR_MAX) begin
                            n_thr = r_thr + sstl_pkg::THR_W'(1);
                        end
                        n_adj = r_adj + sstl_pkg::ADJ_W'(1);
                    end else if (fast) begin
                        if (r_thr > sstl_pkg::THR_MIN) begin
                            n_thr = r_thr - sstl_pkg::THR_W'(1);
                        end
                        n_adj = r_adj + sstl_pkg::ADJ_W'(1);
                    end else begin
                        n_adj = '0;
                    end
                end else begin
                    // duty step phase, restarts sync when the duty steps
                    if (slow) begin
                        n_duty = r_duty + sstl_pkg::DUTY_W'(1);
                        n_sync = '0;
                    end else if (fast) begin
                        n_duty = r_duty - sstl_pkg::DUTY_W'(1);
                        n_sync = '0;
                    end
                    n_adj = '0;
                end
            end
            // duty clip
            if (n_duty > sstl_pkg::DUTY_MAX) begin
                n_duty = sstl_pkg::DUTY_MAX;
            end else if (n_duty < sstl_pkg::DUTY_MIN) begin
                n_duty = sstl_pkg::DUTY_MIN;
            end
            // no back-emf seen
            if (i_data.bemf_zero) begin
                n_duty = sstl_pkg::DUTY_MIN;
                n_thr  = '0;
                n_sync = '0;
            end
        end
    end

    // trim state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_mode.clear) begin
            r_sync     <= '0;
            r_adj      <= '0;
            r_thr      <= '0;
            r_duty     <= sstl_pkg::DUTY_MIN;
            r_last_avg <= '0;
            r_last_err <= '0;
        end else if (take) begin
            r_sync     <= n_sync;
            r_adj      <= n_adj;
            r_thr      <= n_thr;
            r_duty     <= n_duty;
            r_last_avg <= n_last_avg;
            r_last_err <= n_last_err;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_step_us <= i_data.step_us;
            r_eval    <= i_data.eval;
        end
    end

    assign o_valid          = r_valid;
    assign o_pwm_duty       = r_duty;
    assign o_bemf_threshold = r_thr;
    assign o_step_time_us   = r_step_us;
    assign o_avg_step_us    = r_last_avg;
    assign o_step_error     = r_last_err;
    assign o_evaluated      = r_eval;

    // duty stays inside its clip range
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_duty >= sstl_pkg::DUTY_MIN && r_duty <= sstl_pkg::DUTY_MAX)
        else $error("duty out of range");

    // threshold never passes its ceiling
    a_thr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_thr <= sstl_pkg::THR_MAX)
        else $error("threshold out of range");

    // missing back-emf drops duty, threshold and sync
    a_bemf_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !i_mode.stopped && !i_mode.clear && i_data.bemf_zero
        |=> r_duty == sstl_pkg::DUTY_MIN && r_thr == '0 && r_sync == '0)
        else $error("back-emf loss not applied");

    // an item taken while stopped leaves the initial state
    a_stop_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_mode.stopped
        |=> r_duty == sstl_pkg::DUTY_MIN && r_thr == '0 && r_adj == '0
            && r_last_avg == '0 && !r_eval)
        else $error("stopped item changed state");

endmodule
